// File: sv/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the bounded LIFO stack
// Command and status codes, controller states and the ctrl/status bundles.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned StW   = 2;
  localparam int unsigned CapW  = 7;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [CmdW-1:0] {
    CMD_POP     = 2'd0,
    CMD_PUSH    = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_PEEK    = 2'd3
  } cmd_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_fixed;   // load a result with zero data and last set
    status_e fixed_status;
    logic    push_we;      // write the pushed word at the top, count up
    logic    pop_dec;      // count down
    logic    rd_top;       // read the entry below count
    logic    rd_next;      // read the entry below the pointer
    logic    load_rd;      // load a result from read data
    logic    rd_last;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic ptr_zero;
    logic res_last;
  } stat_t;

endpackage

// File: sv/bls_if.sv
// ----------------------------------------------------------------------------
// bls_if: channel interfaces of the bounded LIFO stack
// Command, result and capacity write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface bls_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [bls_pkg::CmdW-1:0]        command;
  logic signed [bls_pkg::DataW-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface bls_res_if;
  logic                            valid;
  logic                            ready;
  logic [bls_pkg::StW-1:0]         status;
  logic signed [bls_pkg::DataW-1:0] data_value;
  logic                            last;

  modport source (output valid, output status, output data_value, output last,
                  input ready);
  modport sink   (input valid, input status, input data_value, input last,
                  output ready);
endinterface

interface bls_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [bls_pkg::CapW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/bls_ram.sv
// ----------------------------------------------------------------------------
// bls_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bls_ctrl.sv
// ----------------------------------------------------------------------------
// bls_ctrl: stack controller
// Decodes one command per transaction and sequences reads and results.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  bls_pkg::cmd_e        cmd_command_i,
  output logic                 cmd_ready_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output bls_pkg::ctrl_t       ctrl_o,
  input  bls_pkg::stat_t       stat_i
);

  bls_pkg::state_e state_q, state_d;
  bls_pkg::cmd_e   op_q, op_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ctrl_o      = '0;
    ctrl_o.fixed_status = bls_pkg::ST_OK;

    unique case (state_q)
      bls_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d = cmd_command_i;
          unique case (cmd_command_i)
            bls_pkg::CMD_PUSH: begin
              ctrl_o.load_fixed = 1'b1;
              if (stat_i.full) begin
                ctrl_o.fixed_status = bls_pkg::ST_OVERFLOW;
              end else begin
                ctrl_o.push_we = 1'b1;
              end
              state_d = bls_pkg::S_RESP;
            end
            bls_pkg::CMD_POP: begin
              if (stat_i.count_zero) begin
                ctrl_o.load_fixed   = 1'b1;
                ctrl_o.fixed_status = bls_pkg::ST_UNDERFLOW;
                state_d = bls_pkg::S_RESP;
              end else begin
                ctrl_o.rd_top  = 1'b1;
                ctrl_o.pop_dec = 1'b1;
                state_d = bls_pkg::S_READ;
              end
            end
            default: begin // display and peek
              if (stat_i.count_zero) begin
                ctrl_o.load_fixed   = 1'b1;
                ctrl_o.fixed_status = bls_pkg::ST_EMPTY;
                state_d = bls_pkg::S_RESP;
              end else begin
                ctrl_o.rd_top = 1'b1;
                state_d = bls_pkg::S_READ;
              end
            end
          endcase
        end
      end
      bls_pkg::S_READ: begin
        ctrl_o.load_rd = 1'b1;
        ctrl_o.rd_last = (op_q != bls_pkg::CMD_DISPLAY) || stat_i.ptr_zero;
        state_d = bls_pkg::S_RESP;
      end
      bls_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          // only a display walk leaves last clear
          if (stat_i.res_last) begin
            state_d = bls_pkg::S_IDLE;
          end else begin
            ctrl_o.rd_next = 1'b1;
            state_d = bls_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = bls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bls_pkg::S_IDLE;
      op_q    <= bls_pkg::CMD_POP;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// File: sv/bls_dpath.sv
// ----------------------------------------------------------------------------
// bls_dpath: stack datapath
// Entry RAM, entry count, walk pointer, capacity register and result register.
// ----------------------------------------------------------------------------
module bls_dpath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [bls_pkg::DataW-1:0] push_value_i,
  input  logic                             cfg_valid_i,
  input  logic [bls_pkg::CapW-1:0]         cfg_data_i,
  input  bls_pkg::ctrl_t                   ctrl_i,
  output bls_pkg::stat_t                   stat_o,
  output logic [bls_pkg::StW-1:0]          status_o,
  output logic signed [bls_pkg::DataW-1:0] data_value_o,
  output logic                             last_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [bls_pkg::CapW-1:0] DepthCap = bls_pkg::CapW'(DEPTH);

  logic [CntW-1:0]                 count_q, count_d;
  logic [CntW-1:0]                 cnt_m1;
  logic [AddrW-1:0]                ptr_q, ptr_d;
  logic [bls_pkg::CapW-1:0]        cap_q, usable;
  bls_pkg::status_e                status_q;
  logic signed [bls_pkg::DataW-1:0] data_q;
  logic                            last_q;
  logic [AddrW-1:0]                raddr;
  logic [bls_pkg::DataW-1:0]       rdata;

  assign cnt_m1 = count_q - CntW'(1);
  assign usable = (cap_q > DepthCap) ? DepthCap : cap_q;

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (bls_pkg::CapW'(count_q) >= usable);
  assign stat_o.ptr_zero   = (ptr_q == '0);
  assign stat_o.res_last   = last_q;

  assign raddr = ctrl_i.rd_top ? cnt_m1[AddrW-1:0] : (ptr_q - AddrW'(1));

  always_comb begin
    count_d = count_q;
    if (ctrl_i.push_we) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop_dec) begin
      count_d = cnt_m1;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.rd_top || ctrl_i.rd_next) begin
      ptr_d = raddr;
    end
  end

  bls_ram #(
    .WIDTH (bls_pkg::DataW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.push_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (push_value_i),
    .re_i    (ctrl_i.rd_top || ctrl_i.rd_next),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= bls_pkg::CapReset;
    end else begin
      count_q <= count_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (ctrl_i.load_fixed) begin
      status_q <= ctrl_i.fixed_status;
      data_q   <= '0;
      last_q   <= 1'b1;
    end else if (ctrl_i.load_rd) begin
      status_q <= bls_pkg::ST_OK;
      data_q   <= rdata;
      last_q   <= ctrl_i.rd_last;
    end
  end

  assign status_o     = status_q;
  assign data_value_o = data_q;
  assign last_o       = last_q;

endmodule

// File: sv/bounded_lifo_stack.sv
// ----------------------------------------------------------------------------
// bounded_lifo_stack: bounded LIFO stack of signed 32-bit words
// Push, pop, peek and display with a configurable usable capacity.
// ----------------------------------------------------------------------------
//  channel  dir  payload                       transfer
//  cmd_i    in   command, push_value           valid & ready
//  res_o    out  status, data_value, last      valid & ready
//  cfg_i    in   data (capacity, 7 bits)       valid & ready, always ready
//
// Push and every error or empty result load the result at command accept.
// Pop and peek add a read state for the registered RAM read port.
// Display of N entries: one RAM read per entry.
// One command is in flight at a time; cmd_i is held off until its last
// result is taken, and res_o stalls simply freeze the sequence.
// Reset empties the stack and sets capacity to 64; RAM contents are kept.
// ----------------------------------------------------------------------------
module bounded_lifo_stack #(
  parameter int unsigned DEPTH = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bls_cmd_if.sink   cmd_i,
  bls_res_if.source res_o,
  bls_cfg_if.sink   cfg_i
);

  bls_pkg::ctrl_t ctrl;
  bls_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;

  bls_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_i.valid),
    .cmd_command_i (bls_pkg::cmd_e'(cmd_i.command)),
    .cmd_ready_o   (cmd_i.ready),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .ctrl_o        (ctrl),
    .stat_i        (stat)
  );

  bls_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_value_i (cmd_i.push_value),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .status_o     (res_o.status),
    .data_value_o (res_o.data_value),
    .last_o       (res_o.last)
  );

endmodule
